### src/u8u2_pkg.sv
// ----------------------------------------------------------------------------
// u8u2_pkg
// Shared types and lead-byte constants for the UTF-8 to UCS-2 stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package u8u2_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [15:0] t_unit;
    typedef logic [1:0]  t_pend;

    // Lead-byte class thresholds
    localparam t_byte LEAD4_MIN = 8'hF0;
    localparam t_byte LEAD3_MIN = 8'hE0;
    localparam t_byte LEAD2_MIN = 8'hC0;

    // Payload masks per lead class and for continuation bytes
    localparam t_byte LEAD4_MASK = 8'h07;
    localparam t_byte LEAD3_MASK = 8'h0F;
    localparam t_byte LEAD2_MASK = 8'h1F;
    localparam t_byte CONT_MASK  = 8'h3F;

    localparam t_byte NUL_BYTE = 8'h00;

    localparam t_unit CAPACITY_RESET = 16'd256;

endpackage

`default_nettype wire

### src/utf8_to_ucs2_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_to_ucs2_stream_decoder_top
// Decodes a NUL-terminated UTF-8 byte stream into 16-bit code units, counts
// characters and ends the string at NUL or when the count reaches capacity.
// ----------------------------------------------------------------------------
// Throughput: 1 input byte per cycle while the result stage is not stalled;
//   decode state is updated in a single pass between the input register
//   and the result register.
// Reset: synchronous active-low; clears decode state, drains both stages and
//   sets capacity to 256.
`default_nettype none

module utf8_to_ucs2_stream_decoder_top (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // configuration
    input  wire                 i_cfg_we,
    input  wire u8u2_pkg::t_unit i_cfg_data,
    // input channel
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire u8u2_pkg::t_byte i_in_byte,
    // output channel
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output u8u2_pkg::t_unit     o_code_unit,
    output logic                o_is_end,
    output u8u2_pkg::t_unit     o_char_count
);
    import u8u2_pkg::*;

    // input stage
    logic  r_in_vld;
    t_byte r_byte;

    // decode state
    t_pend r_pend,  n_pend;
    t_unit r_acc,   n_acc;
    t_unit r_count, n_count;
    logic  r_halt,  n_halt;
    t_unit r_capacity;

    // result stage
    logic  r_out_vld;
    t_unit r_unit;
    logic  r_end;
    t_unit r_cnt_out;

    // decode outputs
    logic  emit;
    t_unit e_unit;
    logic  e_end;
    t_unit e_cnt;
    logic  finish;
    t_unit fin_acc;
    t_unit next_count;
    logic  advance;

    assign advance    = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || advance;
    assign next_count = r_count + 16'd1;

    // single-pass decode of the registered byte
    always_comb begin
        n_pend  = r_pend;
        n_acc   = r_acc;
        n_count = r_count;
        n_halt  = r_halt;
        emit    = 1'b0;
        e_unit  = '0;
        e_end   = 1'b0;
        e_cnt   = r_count;
        finish  = 1'b0;
        fin_acc = '0;

        if (r_halt) begin
            // drop bytes until NUL re-arms the decoder
            if (r_byte == NUL_BYTE) begin
                n_halt  = 1'b0;
                n_pend  = '0;
                n_acc   = '0;
                n_count = '0;
            end
        end else if (r_pend != '0) begin
            // continuation: only low 16 bits of the code point are kept
            n_acc   = {r_acc[9:0], r_byte[5:0] & CONT_MASK[5:0]};
            n_pend  = r_pend - 2'd1;
            fin_acc = n_acc;
            finish  = (r_pend == 2'd1);
        end else if (r_byte == NUL_BYTE) begin
            emit    = 1'b1;
            e_end   = 1'b1;
            e_cnt   = r_count;
            n_pend  = '0;
            n_acc   = '0;
            n_count = '0;
        end else if (r_byte >= LEAD4_MIN) begin
            n_acc  = {8'd0, r_byte & LEAD4_MASK};
            n_pend = 2'd3;
        end else if (r_byte >= LEAD3_MIN) begin
            n_acc  = {8'd0, r_byte & LEAD3_MASK};
            n_pend = 2'd2;
        end else if (r_byte >= LEAD2_MIN) begin
            n_acc  = {8'd0, r_byte & LEAD2_MASK};
            n_pend = 2'd1;
        end else begin
            // single-byte character, stray continuations included
            fin_acc = {8'd0, r_byte};
            finish  = 1'b1;
        end

        // character done: count it, check against capacity
        if (finish) begin
            n_count = next_count;
            n_pend  = '0;
            n_acc   = '0;
            emit    = 1'b1;
            e_cnt   = next_count;
            if (next_count >= r_capacity) begin
                n_halt = 1'b1;
                e_end  = 1'b1;
                e_unit = '0;
            end else begin
                e_unit = fin_acc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_byte <= i_in_byte;
        end
        if (advance && emit) begin
            r_unit    <= e_unit;
            r_end     <= e_end;
            r_cnt_out <= e_cnt;
        end
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pend     <= '0;
            r_acc      <= '0;
            r_count    <= '0;
            r_halt     <= 1'b0;
            r_capacity <= CAPACITY_RESET;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (o_in_ready) begin
                r_in_vld <= i_in_valid;
            end
            if (advance) begin
                r_pend  <= n_pend;
                r_acc   <= n_acc;
                r_count <= n_count;
                r_halt  <= n_halt;
            end
            if (advance && emit) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_code_unit  = r_unit;
    assign o_is_end     = r_end;
    assign o_char_count = r_cnt_out;

endmodule

`default_nettype wire

### src/u8u2_checker.sv
// ----------------------------------------------------------------------------
// u8u2_checker
// Port-level checks for the UTF-8 to UCS-2 stream decoder, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module u8u2_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire u8u2_pkg::t_unit o_code_unit,
    input wire                  o_is_end,
    input wire u8u2_pkg::t_unit o_char_count
);
    import u8u2_pkg::*;

    // stalled result word holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_code_unit) && $stable(o_is_end)
            && $stable(o_char_count))
        else $error("result word changed while stalled");

    // end word never carries a code unit
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_end |-> o_code_unit == t_unit'(0))
        else $error("end word with nonzero code unit");

    // a character word always counts at least one character
    a_char_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_is_end |-> o_char_count != t_unit'(0))
        else $error("character word with zero count");

    // reset drains the result stage
    a_reset_drain: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind utf8_to_ucs2_stream_decoder_top u8u2_checker u_u8u2_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_code_unit  (o_code_unit),
    .o_is_end     (o_is_end),
    .o_char_count (o_char_count)
);

`default_nettype wire
